@@ rtl/fcv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcv_pkg
// Shared widths, defaults and the cell control bundle for the full-length
// convolution filter.
// ----------------------------------------------------------------------------
package fcv_pkg;

  localparam int MaxTapsDefault    = 64;
  localparam int SampleBitsDefault = 16;
  localparam int CoefBits          = 16;
  localparam int ValueBits         = 16;
  localparam int IndexBits         = 6;
  localparam int CountBits         = 7;
  localparam int SumBits           = 38;

  // Operation codes carried by the op field
  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  // One command to every cell of the chain, all cells see the same bundle
  typedef struct packed {
    logic                 shift;
    logic                 rotate;
    logic                 clear;
    logic                 coef_we;
    logic [IndexBits-1:0] coef_index;
    logic [CoefBits-1:0]  coef_data;
    logic [IndexBits-1:0] tap_last;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/fcv_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcv_cell
// One tap of the chain: holds one sample and one coefficient. Samples shift
// towards higher taps; during a sum pass the taps in use rotate towards tap 0.
// ----------------------------------------------------------------------------
module fcv_cell #(
  parameter int INDEX  = 0,
  parameter int SAMP_W = fcv_pkg::SampleBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fcv_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [SAMP_W-1:0]            samp_prev,
  input  logic signed [SAMP_W-1:0]            samp_next,
  input  logic signed [SAMP_W-1:0]            head_samp,
  input  logic signed [fcv_pkg::CoefBits-1:0] coef_next,
  input  logic signed [fcv_pkg::CoefBits-1:0] head_coef,
  output logic signed [SAMP_W-1:0]            samp,
  output logic signed [fcv_pkg::CoefBits-1:0] coef
);
  import fcv_pkg::*;

  localparam logic [IndexBits-1:0] MyIndex = IndexBits'(INDEX);

  logic wrap;
  logic in_use;

  always_comb begin
    wrap   = (ctrl.tap_last == MyIndex);
    in_use = (MyIndex <= ctrl.tap_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samp <= '0;
      coef <= '0;
    end else if (ctrl.clear) begin
      samp <= '0;
    end else if (ctrl.shift) begin
      samp <= samp_prev;
    end else if (ctrl.rotate && in_use) begin
      // the last tap in use takes the head back, closing the ring
      samp <= wrap ? head_samp : samp_next;
      coef <= wrap ? head_coef : coef_next;
    end else if (ctrl.coef_we && (ctrl.coef_index == MyIndex)) begin
      coef <= ctrl.coef_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fcv_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcv_mac
// Multiply-accumulate at the head of the chain: registered product, then a
// full-width accumulate.
// ----------------------------------------------------------------------------
module fcv_mac #(
  parameter int SAMP_W = fcv_pkg::SampleBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                mul_en,
  input  logic signed [SAMP_W-1:0]            a,
  input  logic signed [fcv_pkg::CoefBits-1:0] b,
  output logic signed [fcv_pkg::SumBits-1:0]  acc
);
  import fcv_pkg::*;

  localparam int ProdBits = SAMP_W + CoefBits;

  logic signed [ProdBits-1:0] prod;
  logic                       prod_valid;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= mul_en;
      if (clear) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc + SumBits'(prod);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fir_full_convolution.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_full_convolution
// Full linear convolution of a sample block with a loaded Q1.15 filter,
// built as a chain of tap cells that rotate past one multiply-accumulate.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  in       | in_valid / in_stall   | op, tap_index, value, last_sample
//  out      | out_valid / out_stall | sum, last
//  config   | cfg_we                | cfg_data (tap_count)
//
//  A coefficient load writes value to the tap at tap_index. Each result is
//  formed in steps: the ring of the n taps in use rotates through the one
//  multiplier, a flush step adds the last product, a post step loads the
//  output register. A sample transaction first shifts the sample in; a last
//  sample is followed by n-1 tail results and the delay line is cleared with
//  the final. Reset clears taps, coefficients and tap_count (to 1). An output
//  stall holds the block in the result-load step; a new transaction is taken
//  only once all results of the previous one have entered the output register.
// ----------------------------------------------------------------------------
module fir_full_convolution #(
  parameter int MAX_TAPS    = fcv_pkg::MaxTapsDefault,
  parameter int SAMPLE_BITS = fcv_pkg::SampleBitsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fcv_pkg::CountBits-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [fcv_pkg::IndexBits-1:0]        tap_index,
  input  logic signed [fcv_pkg::ValueBits-1:0] value,
  input  logic                                 last_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fcv_pkg::SumBits-1:0]   sum,
  output logic                                 last
);
  import fcv_pkg::*;

  localparam int SampW = (SAMPLE_BITS < ValueBits) ? SAMPLE_BITS : ValueBits;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_POST  = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [CountBits-1:0] tap_count;
  logic [CountBits-1:0] taps_used;
  logic [IndexBits-1:0] tap_last;
  logic [IndexBits-1:0] step;
  logic [IndexBits-1:0] tail;
  logic                 block_last;

  logic                 in_fire;
  logic                 out_free;
  logic                 acc_clear;
  logic                 mul_en;
  logic signed [SampW-1:0] shift_data;
  cell_ctrl_t           ctrl;

  logic signed [SampW-1:0]    samp [MAX_TAPS];
  logic signed [CoefBits-1:0] coef [MAX_TAPS];
  logic signed [SumBits-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= CountBits'(1);
    end else if (cfg_we) begin
      tap_count <= cfg_data;
    end
  end

  always_comb begin
    if (tap_count == '0) begin
      taps_used = CountBits'(1);
    end else if (tap_count > CountBits'(MAX_TAPS)) begin
      taps_used = CountBits'(MAX_TAPS);
    end else begin
      taps_used = tap_count;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next      = state;
    acc_clear       = 1'b0;
    mul_en          = 1'b0;
    shift_data      = value[SampW-1:0];
    ctrl            = '0;
    ctrl.tap_last   = tap_last;
    ctrl.coef_index = tap_index;
    ctrl.coef_data  = value;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (op == OpLoad) begin
            ctrl.coef_we = 1'b1;
          end else begin
            ctrl.shift = 1'b1;
            acc_clear  = 1'b1;
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        ctrl.rotate = 1'b1;
        mul_en      = 1'b1;
        if (step == tap_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_POST;
      end
      S_POST: begin
        if (out_free) begin
          if (tail == '0) begin
            ctrl.clear = block_last;
            state_next = S_IDLE;
          end else begin
            // feed a zero for the next tail result
            shift_data = '0;
            ctrl.shift = 1'b1;
            acc_clear  = 1'b1;
            state_next = S_RUN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tap_last   <= '0;
      step       <= '0;
      tail       <= '0;
      block_last <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_fire && op == OpSample) begin
        tap_last   <= IndexBits'(taps_used - CountBits'(1));
        block_last <= last_sample;
        tail       <= last_sample ? IndexBits'(taps_used - CountBits'(1)) : '0;
        step       <= '0;
      end else if (state == S_RUN) begin
        step <= step + IndexBits'(1);
      end else if (state == S_POST && out_free && tail != '0) begin
        tail <= tail - IndexBits'(1);
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_POST && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_POST && out_free) begin
      sum  <= acc;
      last <= block_last && (tail == '0);
    end
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    logic signed [SampW-1:0]    prev_s;
    logic signed [SampW-1:0]    next_s;
    logic signed [CoefBits-1:0] next_c;

    if (k == 0) begin : g_first
      assign prev_s = shift_data;
    end else begin : g_inner
      assign prev_s = samp[k-1];
    end

    if (k == MAX_TAPS - 1) begin : g_end
      assign next_s = samp[0];
      assign next_c = coef[0];
    end else begin : g_mid
      assign next_s = samp[k+1];
      assign next_c = coef[k+1];
    end

    fcv_cell #(
      .INDEX  (k),
      .SAMP_W (SampW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .samp_prev (prev_s),
      .samp_next (next_s),
      .head_samp (samp[0]),
      .coef_next (next_c),
      .head_coef (coef[0]),
      .samp      (samp[k]),
      .coef      (coef[k])
    );
  end

  fcv_mac #(
    .SAMP_W (SampW)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (acc_clear),
    .mul_en (mul_en),
    .a      (samp[0]),
    .b      (coef[0]),
    .acc    (acc)
  );

endmodule
`default_nettype wire
